// ===== rtl/mtot_pkg.sv =====
`timescale 1ns / 1ps
// Package for the one-shot timer table: command codes, result kinds,
// controller states and the control/status structs. No dependencies.
package mtot_pkg;

  localparam int MAX_EVENTS = 8;
  localparam int EVT_W      = $clog2(MAX_EVENTS + 1);
  localparam int IDX_W      = 3;
  localparam int TIME_W     = 32;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_ARM   = 2'd1;
  localparam logic [1:0] CMD_CHECK = 2'd2;

  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_CHECK  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic tick;
    logic arm;
    logic check;
    logic step;
    logic flush;
  } ctl_t;

  typedef struct packed {
    logic scan_last;
  } sts_t;

endpackage

// ===== rtl/mtot_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mtot_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mtot_ctrl.sv =====
`timescale 1ns / 1ps
// Controller for the one-shot timer table: decodes commands, sequences
// the expiry scan. Depends on mtot_pkg.
module mtot_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    command,
  input  mtot_pkg::sts_t sts,
  output mtot_pkg::ctl_t ctl,
  output logic          busy
);
  import mtot_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (command == CMD_TICK) begin
            ctl.tick   = 1'b1;
            state_next = ST_SCAN;
          end else if (command == CMD_ARM) begin
            ctl.arm = 1'b1;
          end else if (command == CMD_CHECK) begin
            ctl.check = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        ctl.step = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        ctl.flush  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== rtl/mtot_dp.sv =====
`timescale 1ns / 1ps
// Datapath for the one-shot timer table: time counter, target RAM, armed and
// fired flags, scan counter, held event and result register.
// Depends on mtot_pkg and mtot_ram.
module mtot_dp #(
  parameter int TIMER_COUNT = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mtot_pkg::ctl_t                ctl,
  input  logic [mtot_pkg::IDX_W-1:0]    timer_index,
  input  logic [mtot_pkg::TIME_W-1:0]   period,
  output mtot_pkg::sts_t                sts,
  output logic                          strobe,
  output logic                          kind,
  output logic [mtot_pkg::IDX_W-1:0]    result_index,
  output logic                          fired,
  output logic                          last
);
  import mtot_pkg::*;

  localparam int AW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CW = $clog2(TIMER_COUNT + 1);

  logic [TIME_W-1:0]      now_time;
  logic [TIMER_COUNT-1:0] armed_flags;
  logic [TIMER_COUNT-1:0] fired_flags;
  logic [CW-1:0]          cnt;
  logic [EVT_W-1:0]       evt_cnt;
  logic                   held_v;
  logic [IDX_W-1:0]       held_idx;

  logic [TIME_W-1:0]      rd_data;
  logic [AW-1:0]          cmd_addr;
  logic [AW-1:0]          eval_addr;
  logic                   in_range;
  logic                   hit;
  logic                   take;

  assign cmd_addr  = AW'(timer_index);
  assign eval_addr = AW'(cnt - CW'(1));
  assign in_range  = (int'(timer_index) < TIMER_COUNT);
  assign hit       = armed_flags[eval_addr] && (now_time >= rd_data);
  assign take      = hit && (evt_cnt < EVT_W'(MAX_EVENTS));
  assign sts.scan_last = (cnt == CW'(TIMER_COUNT));

  mtot_ram #(
    .WIDTH (TIME_W),
    .DEPTH (TIMER_COUNT)
  ) u_target (
    .clk   (clk),
    .we    (ctl.arm && in_range),
    .waddr (cmd_addr),
    .wdata (now_time + period),
    .raddr (cnt[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      now_time    <= '0;
      armed_flags <= '0;
      fired_flags <= '0;
      cnt         <= '0;
      evt_cnt     <= '0;
      held_v      <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (ctl.tick) begin
        now_time <= now_time + TIME_W'(1);
        cnt      <= CW'(1);
        evt_cnt  <= '0;
        held_v   <= 1'b0;
      end
      if (ctl.arm && in_range) begin
        armed_flags[cmd_addr] <= 1'b1;
        fired_flags[cmd_addr] <= 1'b0;
      end
      if (ctl.check) begin
        strobe       <= 1'b1;
        kind         <= KIND_CHECK;
        result_index <= timer_index;
        fired        <= in_range && fired_flags[cmd_addr];
        last         <= 1'b1;
        if (in_range && fired_flags[cmd_addr]) begin
          fired_flags[cmd_addr] <= 1'b0;
          armed_flags[cmd_addr] <= 1'b0;
        end
      end
      if (ctl.step) begin
        cnt <= cnt + CW'(1);
        if (hit) begin
          armed_flags[eval_addr] <= 1'b0;
          fired_flags[eval_addr] <= 1'b1;
        end
        // held event goes out only once a later one is known to follow
        if (take) begin
          if (held_v) begin
            strobe       <= 1'b1;
            kind         <= KIND_EXPIRY;
            result_index <= held_idx;
            fired        <= 1'b1;
            last         <= 1'b0;
          end
          held_v   <= 1'b1;
          held_idx <= IDX_W'(eval_addr);
          evt_cnt  <= evt_cnt + EVT_W'(1);
        end
      end
      if (ctl.flush) begin
        cnt    <= '0;
        held_v <= 1'b0;
        if (held_v) begin
          strobe       <= 1'b1;
          kind         <= KIND_EXPIRY;
          result_index <= held_idx;
          fired        <= 1'b1;
          last         <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/multi_timer_one_shot_table.sv =====
`timescale 1ns / 1ps
// Top level of the one-shot timer table: controller plus datapath.
// Depends on mtot_pkg, mtot_ctrl, mtot_dp, mtot_ram.
//
//   channel  handshake              fields
//   input    start & !busy          command, timer_index, period
//   result   strobe (one cycle)     kind, result_index, fired, last
//
// Arm and check leave busy low; a check answer shows in the next cycle.
// A tick keeps busy high through the scan: one target RAM read per entry
// in ST_SCAN, then ST_FLUSH, which sends the last held expiry event.
// Expiry events come out during the scan and right after it, at most 8.
// Reset (rst, synchronous) clears time, armed and fired flags; targets are
// not cleared. The receiver cannot stall: each strobe lasts one cycle.
module multi_timer_one_shot_table #(
  parameter int TIMER_COUNT = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  command,
  input  logic [mtot_pkg::IDX_W-1:0]  timer_index,
  input  logic [mtot_pkg::TIME_W-1:0] period,
  output logic                        strobe,
  output logic                        kind,
  output logic [mtot_pkg::IDX_W-1:0]  result_index,
  output logic                        fired,
  output logic                        last
);
  import mtot_pkg::*;

  ctl_t ctl;
  sts_t sts;

  mtot_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .sts     (sts),
    .ctl     (ctl),
    .busy    (busy)
  );

  mtot_dp #(
    .TIMER_COUNT (TIMER_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .timer_index  (timer_index),
    .period       (period),
    .sts          (sts),
    .strobe       (strobe),
    .kind         (kind),
    .result_index (result_index),
    .fired        (fired),
    .last         (last)
  );

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && command == CMD_TICK |=> busy)
    else $error("tick did not start a scan");

  a_check_last: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == KIND_CHECK |-> last && !busy)
    else $error("check answer not single or during scan");

  a_expiry_fired: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == KIND_EXPIRY |-> fired)
    else $error("expiry event without fired");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == KIND_EXPIRY && !last |-> busy)
    else $error("non-final expiry event after scan end");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == KIND_EXPIRY && last |-> !busy)
    else $error("final expiry event while still scanning");

endmodule
